// ===== rtl/core/rational_add_reduce_unit_macros.svh =====
// Assertion macros shared by the rational add/reduce RTL.
`ifndef RATIONAL_ADD_REDUCE_UNIT_MACROS_SVH
`define RATIONAL_ADD_REDUCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RAR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");
`define RAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define RAR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RAR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/rar_pkg.sv =====
`timescale 1ns / 1ps
package rar_pkg;

   localparam int NUM_WIDTH      = 16;
   localparam int DEN_WIDTH      = NUM_WIDTH - 1;
   localparam int SUM_NUM_WIDTH  = 2 * NUM_WIDTH;
   localparam int SUM_DEN_WIDTH  = 2 * NUM_WIDTH - 2;
   localparam int MAG_WIDTH      = 2 * NUM_WIDTH - 1;
   localparam int DIV_CNT_WIDTH  = $clog2(MAG_WIDTH);
   localparam int SHIFT_WIDTH    = $clog2(SUM_DEN_WIDTH);

   typedef struct packed {
      logic signed [NUM_WIDTH-1:0] a_num;
      logic        [DEN_WIDTH-1:0] a_den;
      logic signed [NUM_WIDTH-1:0] b_num;
      logic        [DEN_WIDTH-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [SUM_NUM_WIDTH-1:0] sum_num;
      logic        [SUM_DEN_WIDTH-1:0] sum_den;
      logic                            equal;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [MAG_WIDTH-1:0] dividend;
      logic [MAG_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [MAG_WIDTH-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_T1,
      ST_MUL_T2,
      ST_MUL_DEN,
      ST_SUM,
      ST_GCD_EVEN,
      ST_GCD_LOOP,
      ST_START_NUM,
      ST_WAIT_NUM,
      ST_START_DEN,
      ST_WAIT_DEN
   } state_type;

endpackage

// ===== rtl/core/rar_div.sv =====
`timescale 1ns / 1ps
`include "rational_add_reduce_unit_macros.svh"
module rar_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rar_pkg::div_req_type div_req,
   output rar_pkg::div_rsp_type div_rsp
);

   localparam int W  = rar_pkg::MAG_WIDTH;
   localparam int CW = rar_pkg::DIV_CNT_WIDTH;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [W:0]    trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
   end

   // restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = CW'(W - 1);
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
         end
         quo_in   = {quo_ff[W-2:0], ~trial[W]};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   `RAR_ASSERT_IMPLY(a_div_no_restart, clock, reset, div_req.start, !busy_ff)
   `RAR_ASSERT_NEXT(a_div_last_step, clock, reset, busy_ff && (count_ff == '0), done_ff)
   `RAR_ASSERT_NEXT(a_div_done_idle, clock, reset, done_ff, !busy_ff && !done_ff)

endmodule

// ===== rtl/core/rational_add_reduce_unit.sv =====
// Channel    Ports                      Handshake
// request    req_data, start, busy      taken when start && !busy
// response   rsp_data, rsp_valid        one-cycle strobe, no backpressure
//
// One request at a time; busy stays high until its response is strobed.
// Steps: the three products and the sum, removal of the shared factors of
// two, the binary GCD loop, two divisions on the shared divider and the
// registered response strobe.
// A zero sum skips the GCD loop and divisions and answers from ST_GCD_EVEN.
// Reset is synchronous and clears the sequencer and the response strobe.
`timescale 1ns / 1ps
`include "rational_add_reduce_unit_macros.svh"
module rational_add_reduce_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rar_pkg::req_type req_data,
   output logic             rsp_valid,
   output rar_pkg::rsp_type rsp_data
);

   localparam int NW  = rar_pkg::NUM_WIDTH;
   localparam int DW  = rar_pkg::DEN_WIDTH;
   localparam int SNW = rar_pkg::SUM_NUM_WIDTH;
   localparam int SDW = rar_pkg::SUM_DEN_WIDTH;
   localparam int MW  = rar_pkg::MAG_WIDTH;
   localparam int SW  = rar_pkg::SHIFT_WIDTH;

   rar_pkg::state_type    state_ff, state_in;
   logic signed [NW-1:0]  an_ff, an_in, bn_ff, bn_in;
   logic [DW-1:0]         ad_ff, ad_in, bd_ff, bd_in;
   logic signed [SNW-1:0] t1_ff, t1_in, t2_ff, t2_in;
   logic [SDW-1:0]        den_ff, den_in;
   logic [MW-1:0]         mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  equal_ff, equal_in;
   logic [MW-1:0]         gx_ff, gx_in, gy_ff, gy_in;
   logic [SW-1:0]         shift_ff, shift_in;
   logic [MW-1:0]         qnum_ff, qnum_in;
   rar_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic signed [NW-1:0]  mul_a, mul_b;
   logic signed [SNW-1:0] mul_p;
   logic [SNW-1:0]        sum_pos, sum_neg;
   logic [MW:0]           d_xy, d_yx;
   rar_pkg::div_req_type  div_req;
   rar_pkg::div_rsp_type  div_rsp;

   rar_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rar_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      an_ff    <= an_in;
      bn_ff    <= bn_in;
      ad_ff    <= ad_in;
      bd_ff    <= bd_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      den_ff   <= den_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      equal_ff <= equal_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      shift_ff <= shift_in;
      qnum_ff  <= qnum_in;
      rsp_ff   <= rsp_in;
   end

   // shared multiplier: denominators enter zero-extended as positive signed values
   always_comb begin
      unique case (state_ff)
         rar_pkg::ST_MUL_T1: begin
            mul_a = an_ff;
            mul_b = {1'b0, bd_ff};
         end
         rar_pkg::ST_MUL_T2: begin
            mul_a = bn_ff;
            mul_b = {1'b0, ad_ff};
         end
         default: begin
            mul_a = {1'b0, ad_ff};
            mul_b = {1'b0, bd_ff};
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign sum_pos = t1_ff + t2_ff;
   assign sum_neg = ~t1_ff - t2_ff + SNW'(1);
   assign d_xy    = {1'b0, gx_ff} - {1'b0, gy_ff};
   assign d_yx    = {1'b0, gy_ff} - {1'b0, gx_ff};

   always_comb begin
      state_in     = state_ff;
      an_in        = an_ff;
      bn_in        = bn_ff;
      ad_in        = ad_ff;
      bd_in        = bd_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      den_in       = den_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      equal_in     = equal_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      shift_in     = shift_ff;
      qnum_in      = qnum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = mag_ff;
      div_req.divisor  = gy_ff;

      unique case (state_ff)
         rar_pkg::ST_IDLE: begin
            if (start) begin
               an_in    = req_data.a_num;
               bn_in    = req_data.b_num;
               // read a zero denominator as one
               ad_in    = (req_data.a_den == '0) ? DW'(1) : req_data.a_den;
               bd_in    = (req_data.b_den == '0) ? DW'(1) : req_data.b_den;
               state_in = rar_pkg::ST_MUL_T1;
            end
         end
         rar_pkg::ST_MUL_T1: begin
            t1_in    = mul_p;
            state_in = rar_pkg::ST_MUL_T2;
         end
         rar_pkg::ST_MUL_T2: begin
            t2_in    = mul_p;
            state_in = rar_pkg::ST_MUL_DEN;
         end
         rar_pkg::ST_MUL_DEN: begin
            den_in   = mul_p[SDW-1:0];
            state_in = rar_pkg::ST_SUM;
         end
         rar_pkg::ST_SUM: begin
            neg_in   = sum_pos[SNW-1];
            mag_in   = sum_pos[SNW-1] ? sum_neg[MW-1:0] : sum_pos[MW-1:0];
            gx_in    = sum_pos[SNW-1] ? sum_neg[MW-1:0] : sum_pos[MW-1:0];
            gy_in    = MW'(den_ff);
            equal_in = (t1_ff == t2_ff);
            shift_in = '0;
            state_in = rar_pkg::ST_GCD_EVEN;
         end
         rar_pkg::ST_GCD_EVEN: begin
            if (gx_ff == '0) begin
               rsp_in.sum_num = '0;
               rsp_in.sum_den = SDW'(1);
               rsp_in.equal   = equal_ff;
               rsp_valid_in   = 1'b1;
               state_in       = rar_pkg::ST_IDLE;
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in    = gx_ff >> 1;
               gy_in    = gy_ff >> 1;
               shift_in = shift_ff + 1'b1;
            end else begin
               state_in = rar_pkg::ST_GCD_LOOP;
            end
         end
         rar_pkg::ST_GCD_LOOP: begin
            if (gx_ff == '0) begin
               // restore the common factors of two
               gy_in    = gy_ff << shift_ff;
               state_in = rar_pkg::ST_START_NUM;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (!d_xy[MW]) begin
               gx_in = d_xy[MW:1];
            end else begin
               gy_in = d_yx[MW:1];
            end
         end
         rar_pkg::ST_START_NUM: begin
            div_req.start = 1'b1;
            state_in      = rar_pkg::ST_WAIT_NUM;
         end
         rar_pkg::ST_WAIT_NUM: begin
            if (div_rsp.done) begin
               qnum_in  = div_rsp.quotient;
               state_in = rar_pkg::ST_START_DEN;
            end
         end
         rar_pkg::ST_START_DEN: begin
            div_req.start    = 1'b1;
            div_req.dividend = MW'(den_ff);
            state_in         = rar_pkg::ST_WAIT_DEN;
         end
         rar_pkg::ST_WAIT_DEN: begin
            div_req.dividend = MW'(den_ff);
            if (div_rsp.done) begin
               rsp_in.sum_num = neg_ff ? -SNW'(qnum_ff) : SNW'(qnum_ff);
               rsp_in.sum_den = div_rsp.quotient[SDW-1:0];
               rsp_in.equal   = equal_ff;
               rsp_valid_in   = 1'b1;
               state_in       = rar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rar_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != rar_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RAR_ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid_ff, !busy)
   `RAR_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff || $past(start))
   `RAR_ASSERT_IMPLY(a_rsp_den_nonzero, clock, reset, rsp_valid_ff, rsp_ff.sum_den != '0)
   `RAR_ASSERT_IMPLY(a_gcd_nonzero, clock, reset, state_ff == rar_pkg::ST_START_NUM, gy_ff != '0)

endmodule
